// ===== design/pcdf_pkg.sv =====
// Shared types and constants for the PWM duty and frequency capture block.
// No dependencies; every other file in the design imports this package.
package pcdf_pkg;

    // capture counter and field widths
    localparam int CNT_W    = 16;
    localparam int PER_W    = CNT_W + 1;
    localparam int RATE_W   = 24;
    localparam int DUTY_W   = 7;

    // bit-serial divider sizing
    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = 5;

    // command codes
    localparam logic CMD_ARM  = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    localparam logic [RATE_W-1:0] TICK_RATE_RESET = 24'd1000000;

    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] capture_time;
        logic             edge_rising;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_percent;
        logic [RATE_W-1:0] frequency_hz;
        logic [CNT_W-1:0]  high_ticks;
        logic [PER_W-1:0]  period_ticks;
        logic              zero_period;
    } out_item_t;

    // finished edge sequence handed from the sequencer to the top level
    typedef struct packed {
        logic             fire;
        logic [CNT_W-1:0] high;
        logic [PER_W-1:0] period;
    } meas_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RISE1,
        PH_FALL,
        PH_RISE2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DUTY,
        ST_FREQ,
        ST_HOLD
    } calc_state_t;

endpackage

// ===== design/pcdf_seq.sv =====
// Edge sequencer: tracks arm, first rise, fall and second rise, keeps the
// timestamps and produces high time and period. Depends on pcdf_pkg.
module pcdf_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  pcdf_pkg::in_item_t item,
    output pcdf_pkg::meas_t   meas
);
    import pcdf_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] first_rise_reg, first_rise_next;
    logic [CNT_W-1:0] fall_reg, fall_next;
    logic [CNT_W-1:0] high_reg, high_next;
    logic [PER_W-1:0] period_reg, period_next;
    logic [CNT_W-1:0] high_calc;
    logic [CNT_W-1:0] low_calc;
    logic             fire;

    // differences modulo the counter width
    assign high_calc = fall_reg - first_rise_reg;
    assign low_calc  = item.capture_time - fall_reg;

    // phase register and timestamps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            first_rise_reg <= '0;
            fall_reg       <= '0;
            high_reg       <= '0;
            period_reg     <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            first_rise_reg <= first_rise_next;
            fall_reg       <= fall_next;
            high_reg       <= high_next;
            period_reg     <= period_next;
        end
    end

    // next phase; wrong polarity edges leave everything as is
    always_comb
    begin
        phase_next      = phase_reg;
        first_rise_next = first_rise_reg;
        fall_next       = fall_reg;
        high_next       = high_reg;
        period_next     = period_reg;
        fire            = 1'b0;
        if (accept)
        begin
            if (item.cmd == CMD_ARM)
            begin
                phase_next = PH_RISE1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_RISE1:
                    begin
                        if (item.edge_rising)
                        begin
                            first_rise_next = item.capture_time;
                            phase_next      = PH_FALL;
                        end
                    end
                    PH_FALL:
                    begin
                        if (!item.edge_rising)
                        begin
                            fall_next  = item.capture_time;
                            phase_next = PH_RISE2;
                        end
                    end
                    PH_RISE2:
                    begin
                        if (item.edge_rising)
                        begin
                            high_next   = high_calc;
                            period_next = PER_W'(high_calc) + PER_W'(low_calc);
                            phase_next  = PH_IDLE;
                            fire        = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign meas.fire   = fire;
    assign meas.high   = high_reg;
    assign meas.period = period_reg;

endmodule

// ===== design/pcdf_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pcdf_pkg for the dividend, divisor and counter widths.
module pcdf_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pcdf_pkg::DIV_W-1:0] dividend,
    input  logic [pcdf_pkg::PER_W-1:0] divisor,
    output logic                       done,
    output logic [pcdf_pkg::DIV_W-1:0] quotient
);
    import pcdf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     num_reg, num_next;
    logic [PER_W-1:0]     rem_reg, rem_next;
    logic [PER_W-1:0]     dsr_reg, dsr_next;
    logic [PER_W:0]       trial;
    logic                 ge;

    // shift in the next dividend bit and compare
    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // one restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            num_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_W-2:0], ge};
            if (ge)
            begin
                rem_next = PER_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[PER_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== design/pwm_capture_duty_frequency.sv =====
// Top level of the PWM duty and frequency capture block.
// Depends on pcdf_pkg, pcdf_seq and pcdf_div.
//
// Arm and edge items are taken one per cycle while no measurement is being
// computed. The edge that closes a sequence (second rise) starts the
// calculation: a load step, then two passes through the single bit-serial
// divider (duty, then frequency), each handing its quotient over, then a
// load of the output register. in_stall stays high while this runs, until
// the output register is loaded. The finished result sits in an output
// register, so further arm and edge items are taken while it waits for
// the consumer; if a second result finishes while the first still waits,
// in_stall stays high until the output register frees up. A zero period
// skips the divider and gives zero duty and frequency. tick_rate_hz
// resets to 1000000 and is written through cfg_wr_en / cfg_wr_data.
module pwm_capture_duty_frequency (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  pcdf_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output pcdf_pkg::out_item_t               out_item,
    input  logic                              cfg_wr_en,
    input  logic [pcdf_pkg::RATE_W-1:0]       cfg_wr_data
);
    import pcdf_pkg::*;

    calc_state_t       state_reg, state_next;
    logic [RATE_W-1:0] rate_reg;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [RATE_W-1:0] freq_reg, freq_next;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic              in_accept;
    logic              out_load;
    meas_t             meas;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic              div_done;
    logic [DIV_W-1:0]  div_quotient;
    logic [DIV_W-1:0]  high_x100;
    logic              zero_per;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    pcdf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (in_item),
        .meas   (meas)
    );

    pcdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (meas.period),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // high times 100 as shifted adds
    assign high_x100 = (DIV_W'(meas.high) << 6) + (DIV_W'(meas.high) << 5)
                     + (DIV_W'(meas.high) << 2);
    assign zero_per  = (meas.period == '0);

    // tick rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= TICK_RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            rate_reg <= cfg_wr_data;
        end
    end

    // control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        duty_reg <= duty_next;
        freq_reg <= freq_next;
        if (out_load)
        begin
            out_item_reg.duty_percent <= duty_reg;
            out_item_reg.frequency_hz <= freq_reg;
            out_item_reg.high_ticks   <= meas.high;
            out_item_reg.period_ticks <= meas.period;
            out_item_reg.zero_period  <= zero_per;
        end
    end

    // calculation sequence
    always_comb
    begin
        state_next   = state_reg;
        duty_next    = duty_reg;
        freq_next    = freq_reg;
        div_start    = 1'b0;
        div_dividend = high_x100;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (meas.fire)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (zero_per)
                begin
                    duty_next  = '0;
                    freq_next  = '0;
                    state_next = ST_HOLD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DUTY;
                end
            end
            ST_DUTY:
            begin
                if (div_done)
                begin
                    duty_next    = div_quotient[DUTY_W-1:0];
                    div_dividend = DIV_W'(rate_reg);
                    div_start    = 1'b1;
                    state_next   = ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                if (div_done)
                begin
                    freq_next  = div_quotient[RATE_W-1:0];
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== design/pcdf_checker.sv =====
// Port-level checks for the PWM duty and frequency capture block, bound
// to the top level. Depends on pcdf_pkg and pwm_capture_duty_frequency.
module pcdf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input pcdf_pkg::out_item_t         out_item
);
    import pcdf_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed or dropped while stalled");

    // results never appear the cycle after an item is taken
    a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared right after an accepted item");

    // zero flag agrees with the period
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.zero_period == (out_item.period_ticks == '0))
        else $error("zero_period does not match period_ticks");

    // zero period gives zero duty and frequency
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.zero_period
            |-> out_item.duty_percent == '0 && out_item.frequency_hz == '0)
        else $error("nonzero duty or frequency with zero period");

    // duty cannot exceed one hundred percent
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.duty_percent <= DUTY_W'(100))
        else $error("duty above one hundred percent");

endmodule

bind pwm_capture_duty_frequency pcdf_checker u_pcdf_checker (.*);
